// ===== hdl/prw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prewitt edge magnitude package
// Shared widths, register codes, reset values and small types.
// ----------------------------------------------------------------------------
package prw_pkg;

    localparam int PIX_W       = 8;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 16;
    localparam int IMG_W_W     = 11;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int SUM_W       = PIX_W + 2;
    localparam int MAG_W       = SUM_W + 1;

    localparam int LINE_MAX_DEF = 1024;
    localparam int MIN_DIM      = 3;
    localparam int WIN_EDGE     = MIN_DIM - 1;
    localparam int MAG_MAX      = 255;

    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = IMG_W_W'(512);
    localparam logic [ROW_W-1:0]   HEIGHT_RESET = ROW_W'(512);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t top;
        pix_t mid;
    } lb_taps_t;

endpackage

// ===== hdl/prw_pix_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel stream interface
// Valid/ready channel carrying one pixel and its frame start mark per item.
// ----------------------------------------------------------------------------
interface prw_pix_if
    import prw_pkg::*;
();
    logic valid;
    logic ready;
    pix_t pixel;
    logic frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// ===== hdl/prw_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge result interface
// Valid/ready channel carrying one edge magnitude with its position per item.
// ----------------------------------------------------------------------------
interface prw_res_if
    import prw_pkg::*;
();
    logic             valid;
    logic             ready;
    pix_t             magnitude;
    logic [COL_W-1:0] centre_col;
    logic [ROW_W-1:0] centre_row;
    logic             last;

    modport source (output valid, output magnitude, output centre_col,
                    output centre_row, output last, input ready);
    modport sink   (input valid, input magnitude, input centre_col,
                    input centre_row, input last, output ready);
endinterface

// ===== hdl/prewitt_edge_magnitude_3x3_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prewitt edge magnitude, 3x3, streaming
// Raster pixels in, one saturated |gx|+|gy| per interior pixel out.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries                                   Handshake
//  pixels    in         pixel, frame_start                        valid/ready
//  results   out        magnitude, centre_col, centre_row, last   valid/ready
//  cfg       in         cfg_index, cfg_data                       cfg_we only
//
//  One item is taken per cycle unless the read stage is held; a result passes
//  the read stage and line buffer read register, then the output register.
//  Reset clears the counters, the window and all valid flags; the line
//  buffers are not cleared.
//  A result waiting at the output stalls the read stage only when the next
//  item also gives a result.
// ----------------------------------------------------------------------------
module prewitt_edge_magnitude_3x3_top
    import prw_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    prw_pix_if.sink               pixels,
    prw_res_if.source             results
);

    localparam int CW = $clog2(LINE_MAX);

    logic [IMG_W_W-1:0] width_reg;
    logic [ROW_W-1:0]   height_reg;
    logic [CW-1:0]      col_reg;
    logic [CW-1:0]      col_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [31:0]        width32;
    logic [CW-1:0]      col_last;
    logic [ROW_W-1:0]   row_last;
    logic [CW-1:0]      cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic               col_wrap;
    logic               row_wrap;
    logic               accept;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    pix_t               s1_px_reg;
    logic [CW-1:0]      s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic               s1_produce_reg;
    logic               s1_last_reg;
    logic               s1_adv;
    logic               emit;

    logic               out_valid_reg;
    logic               out_valid_next;
    pix_t               out_mag_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic               out_last_reg;

    lb_taps_t           taps;
    pix_t               magnitude;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[ROW_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        width32 = 32'(width_reg);
        if (width32 < 32'(MIN_DIM))
        begin
            col_last = CW'(MIN_DIM - 1);
        end
        else if (width32 > 32'(LINE_MAX))
        begin
            col_last = CW'(LINE_MAX - 1);
        end
        else
        begin
            col_last = CW'(width32 - 32'd1);
        end
        if (height_reg < ROW_W'(MIN_DIM))
        begin
            row_last = ROW_W'(MIN_DIM - 1);
        end
        else
        begin
            row_last = height_reg - ROW_W'(1);
        end
    end

    assign cur_col  = pixels.frame_start ? '0 : col_reg;
    assign cur_row  = pixels.frame_start ? '0 : row_reg;
    assign col_wrap = (cur_col >= col_last);
    assign row_wrap = (cur_row >= row_last);

    always_comb
    begin
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : cur_row + ROW_W'(1);
        end
        else
        begin
            col_next = cur_col + CW'(1);
            row_next = cur_row;
        end
    end

    assign emit          = s1_valid_reg && s1_produce_reg;
    assign s1_adv        = s1_valid_reg && (!s1_produce_reg || !out_valid_reg || results.ready);
    assign pixels.ready  = !s1_valid_reg || s1_adv;
    assign accept        = pixels.valid && pixels.ready;
    assign s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_comb
    begin
        priority if (s1_adv && s1_produce_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg      <= pixels.pixel;
            s1_col_reg     <= cur_col;
            s1_row_reg     <= cur_row;
            s1_produce_reg <= (cur_row >= ROW_W'(WIN_EDGE)) && (cur_col >= CW'(WIN_EDGE));
            s1_last_reg    <= col_wrap && row_wrap;
        end
        if (s1_adv && emit)
        begin
            out_mag_reg  <= magnitude;
            out_col_reg  <= COL_W'(s1_col_reg - CW'(1));
            out_row_reg  <= s1_row_reg - ROW_W'(1);
            out_last_reg <= s1_last_reg;
        end
    end

    prw_linebuf #(
        .LINE_MAX (LINE_MAX)
    ) u_linebuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (cur_col),
        .px      (pixels.pixel),
        .commit  (s1_adv),
        .taps    (taps)
    );

    prw_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (s1_adv),
        .taps      (taps),
        .px        (s1_px_reg),
        .magnitude (magnitude)
    );

    assign results.valid      = out_valid_reg;
    assign results.magnitude  = out_mag_reg;
    assign results.centre_col = out_col_reg;
    assign results.centre_row = out_row_reg;
    assign results.last       = out_last_reg;

endmodule

// ===== hdl/prw_linebuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prewitt line buffers
// Two row memories holding the two rows above the incoming pixel.
// ----------------------------------------------------------------------------
module prw_linebuf
    import prw_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [$clog2(LINE_MAX)-1:0] rd_addr,
    input  pix_t                        px,
    input  logic                        commit,
    output lb_taps_t                    taps
);

    localparam int AW = $clog2(LINE_MAX);

    pix_t          upper_mem [LINE_MAX];
    pix_t          middle_mem [LINE_MAX];
    pix_t          top_rd_reg;
    pix_t          mid_rd_reg;
    logic [AW-1:0] wr_addr_reg;
    pix_t          byp_data_reg;
    logic          byp_reg;
    logic          byp_next;

    // The upper row is written when the item leaves the read stage, so a
    // read of the same column in that cycle takes the pending value.
    assign byp_next = rd_en ? (commit && (rd_addr == wr_addr_reg)) : byp_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            top_rd_reg          <= upper_mem[rd_addr];
            mid_rd_reg          <= middle_mem[rd_addr];
            middle_mem[rd_addr] <= px;
            wr_addr_reg         <= rd_addr;
            byp_data_reg        <= mid_rd_reg;
        end
        if (commit)
        begin
            upper_mem[wr_addr_reg] <= mid_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= byp_next;
        end
    end

    assign taps.top = byp_reg ? byp_data_reg : top_rd_reg;
    assign taps.mid = mid_rd_reg;

endmodule

// ===== hdl/prw_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prewitt window and gradient
// 3x3 pixel window and the saturated sum of absolute gradients.
// ----------------------------------------------------------------------------
module prw_window
    import prw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     shift_en,
    input  lb_taps_t taps,
    input  pix_t     px,
    output pix_t     magnitude
);

    pix_t             win_reg [9];
    logic [SUM_W-1:0] gx_left;
    logic [SUM_W-1:0] gx_right;
    logic [SUM_W-1:0] gy_top;
    logic [SUM_W-1:0] gy_bottom;
    logic [SUM_W-1:0] abs_gx;
    logic [SUM_W-1:0] abs_gy;
    logic [MAG_W-1:0] mag_sum;

    // Sums are taken over the window as it stands after this item's shift.
    always_comb
    begin
        gx_left   = SUM_W'(win_reg[1]) + SUM_W'(win_reg[4]) + SUM_W'(win_reg[7]);
        gx_right  = SUM_W'(taps.top) + SUM_W'(taps.mid) + SUM_W'(px);
        gy_top    = SUM_W'(win_reg[1]) + SUM_W'(win_reg[2]) + SUM_W'(taps.top);
        gy_bottom = SUM_W'(win_reg[7]) + SUM_W'(win_reg[8]) + SUM_W'(px);
        abs_gx    = (gx_left >= gx_right) ? gx_left - gx_right : gx_right - gx_left;
        abs_gy    = (gy_top >= gy_bottom) ? gy_top - gy_bottom : gy_bottom - gy_top;
        mag_sum   = MAG_W'(abs_gx) + MAG_W'(abs_gy);
        if (mag_sum > MAG_W'(MAG_MAX))
        begin
            magnitude = PIX_W'(MAG_MAX);
        end
        else
        begin
            magnitude = PIX_W'(mag_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (shift_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i*3]     <= win_reg[i*3 + 1];
                win_reg[i*3 + 1] <= win_reg[i*3 + 2];
            end
            win_reg[2] <= taps.top;
            win_reg[5] <= taps.mid;
            win_reg[8] <= px;
        end
    end

endmodule

// ===== hdl/prw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prewitt port checker
// Assertions on the top level's channels, attached by bind.
// ----------------------------------------------------------------------------
module prw_checker
    import prw_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             res_valid,
    input logic             res_ready,
    input pix_t             res_magnitude,
    input logic [COL_W-1:0] res_col,
    input logic [ROW_W-1:0] res_row,
    input logic             res_last
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_magnitude) && $stable(res_col)
            && $stable(res_row) && $stable(res_last))
        else $error("result payload changed while stalled");

    a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without an item two cycles before");

    a_res_interior: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_col != '0) && (res_row != '0))
        else $error("result on the frame border");

endmodule

bind prewitt_edge_magnitude_3x3_top prw_checker u_prw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pixels.valid),
    .in_ready      (pixels.ready),
    .res_valid     (results.valid),
    .res_ready     (results.ready),
    .res_magnitude (results.magnitude),
    .res_col       (results.centre_col),
    .res_row       (results.centre_row),
    .res_last      (results.last)
);

// ===== dv/tb_prewitt_edge_magnitude_3x3_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prewitt edge magnitude testbench
// Streams raster pixels through the block under several frame sizes and
// handshake patterns. Results are checked against an in-bench line buffer
// and window model that computes the expected magnitude and position.
// ----------------------------------------------------------------------------
module tb_prewitt_edge_magnitude_3x3_top;
    import prw_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int LONG_HOLD      = 400;
    localparam int ITEMS_PER_MODE = 180;

    localparam pix_t DIRECT_PIXELS [25] = '{
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd0,   8'd0,
        8'd10,  8'd20,  8'd30,  8'd40,  8'd50,  8'd60,  8'd70,  8'd80,  8'd90,
        8'd0,   8'd255, 8'd0,   8'd255, 8'd255, 8'd0,   8'd128
    };
    localparam logic [24:0] DIRECT_STARTS = (25'd1 << 0) | (25'd1 << 22);

    typedef enum int { TEX_NOISE, TEX_BINARY, TEX_FLAT } texture_t;

    typedef struct packed {
        pix_t pixel;
        logic frame_start;
    } pix_item_t;

    typedef struct packed {
        pix_t             magnitude;
        logic [COL_W-1:0] centre_col;
        logic [ROW_W-1:0] centre_row;
        logic             last;
    } edge_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    prw_pix_if pix_bus ();
    prw_res_if res_bus ();

    prewitt_edge_magnitude_3x3_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix_bus),
        .results   (res_bus)
    );

    pix_item_t pending_pixels [$];
    edge_t     expected_edges [$];
    pix_item_t next_pixel;
    logic      pix_taken;

    int pushed;
    int accepted;
    int errors;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int hold_seen;
    int hold_left;

    logic [IMG_W_W-1:0] img_width;
    logic [ROW_W-1:0]   img_height;
    pix_t               lb_upper  [LINE_MAX_DEF];
    pix_t               lb_middle [LINE_MAX_DEF];
    pix_t               win [9];
    logic [COL_W-1:0]   col_pos;
    logic [ROW_W-1:0]   row_pos;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("prewitt_edge_magnitude_3x3_top: mismatch");
            $finish;
        end
    end

    function automatic void predict_edge(input pix_t px, input logic fs);
        int    w;
        int    h;
        int    c;
        int    r;
        int    gxl;
        int    gxr;
        int    gyt;
        int    gyb;
        int    mag;
        pix_t  top;
        pix_t  mid;
        edge_t res;
        w = int'(img_width);
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > LINE_MAX_DEF) w = LINE_MAX_DEF;
        h = int'(img_height);
        if (h < MIN_DIM) h = MIN_DIM;
        if (fs)
        begin
            col_pos = '0;
            row_pos = '0;
        end
        c = int'(col_pos);
        r = int'(row_pos);
        top = lb_upper[c];
        mid = lb_middle[c];
        lb_upper[c] = mid;
        lb_middle[c] = px;
        for (int i = 0; i < 3; i++)
        begin
            win[i * 3] = win[i * 3 + 1];
            win[i * 3 + 1] = win[i * 3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px;
        if (r >= WIN_EDGE && c >= WIN_EDGE)
        begin
            gxl = int'(win[0]) + int'(win[3]) + int'(win[6]);
            gxr = int'(win[2]) + int'(win[5]) + int'(win[8]);
            gyt = int'(win[0]) + int'(win[1]) + int'(win[2]);
            gyb = int'(win[6]) + int'(win[7]) + int'(win[8]);
            mag = (gxl > gxr ? gxl - gxr : gxr - gxl) + (gyt > gyb ? gyt - gyb : gyb - gyt);
            if (mag > MAG_MAX) mag = MAG_MAX;
            res.magnitude  = pix_t'(mag);
            res.centre_col = COL_W'(c - 1);
            res.centre_row = ROW_W'(r - 1);
            res.last       = (c >= w - 1) && (r >= h - 1);
            expected_edges.push_back(res);
        end
        if (c >= w - 1)
        begin
            col_pos = '0;
            row_pos = (r >= h - 1) ? '0 : ROW_W'(r + 1);
        end
        else
        begin
            col_pos = COL_W'(c + 1);
        end
    endfunction

    task automatic check_edge();
        edge_t got;
        edge_t want;
        got = {res_bus.magnitude, res_bus.centre_col, res_bus.centre_row, res_bus.last};
        if (expected_edges.size() == 0)
        begin
            errors = errors + 1;
            if (errors <= 100)
                $display("%0t: expected no result, got mag=%0d col=%0d row=%0d last=%0b",
                         $time, got.magnitude, got.centre_col, got.centre_row, got.last);
        end
        else
        begin
            want = expected_edges.pop_front();
            if (got.magnitude !== want.magnitude || got.centre_col !== want.centre_col ||
                got.centre_row !== want.centre_row || got.last !== want.last)
            begin
                errors = errors + 1;
                if (errors <= 100)
                    $display("%0t: expected %0d,%0d,%0d,%0b got %0d,%0d,%0d,%0b",
                             $time, want.magnitude, want.centre_col, want.centre_row,
                             want.last, got.magnitude, got.centre_col, got.centre_row,
                             got.last);
            end
        end
    endtask

    always @(posedge clk)
    begin
        pix_taken <= pix_bus.valid && pix_bus.ready;
        if (pix_bus.valid && pix_bus.ready)
        begin
            accepted = accepted + 1;
            predict_edge(pix_bus.pixel, pix_bus.frame_start);
        end
        if (res_bus.valid && res_bus.ready)
            check_edge();
    end

    always @(negedge clk)
    begin
        if (rst_n && (!pix_bus.valid || pix_taken))
        begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_pixel = pending_pixels.pop_front();
                pix_bus.valid       <= 1'b1;
                pix_bus.pixel       <= next_pixel.pixel;
                pix_bus.frame_start <= next_pixel.frame_start;
            end
            else
            begin
                pix_bus.valid       <= 1'b0;
                pix_bus.pixel       <= pix_t'($urandom);
                pix_bus.frame_start <= 1'($urandom);
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen     <= hold_req;
            hold_left     <= LONG_HOLD;
            res_bus.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            res_bus.ready <= 1'b0;
        end
        else
        begin
            res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            img_width = data[IMG_W_W-1:0];
        else
            img_height = data[ROW_W-1:0];
    endtask

    task automatic set_size(input int width_val, input int height_val);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data[IMG_W_W-1:0] = IMG_W_W'(width_val);
        write_reg(REG_IMAGE_WIDTH, data);
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(height_val));
    endtask

    task automatic push_run(input int count, input texture_t tex, input int restart_pct,
                            input bit start_frame);
        pix_item_t item;
        for (int k = 0; k < count; k++)
        begin
            case (tex)
                TEX_NOISE:  item.pixel = pix_t'($urandom);
                TEX_BINARY: item.pixel = $urandom_range(1) ? 8'hFF : 8'h00;
                default:    item.pixel = pix_t'($urandom_range(96, 104));
            endcase
            item.frame_start = (k == 0) ? start_frame : ($urandom_range(99) < restart_pct);
            pending_pixels.push_back(item);
            pushed = pushed + 1;
        end
    endtask

    task automatic wait_drained();
        while (accepted != pushed || expected_edges.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int  mode_items;
        int  w;
        int  h;
        int  eff_w;
        int  eff_h;
        int  n;
        bit  wide;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        pix_bus.valid       = 1'b0;
        pix_bus.pixel       = '0;
        pix_bus.frame_start = 1'b0;
        res_bus.ready       = 1'b0;
        pix_taken           = 1'b0;
        pushed              = 0;
        accepted            = 0;
        errors              = 0;
        cycles              = 0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        hold_req            = 0;
        hold_seen           = 0;
        hold_left           = 0;
        img_width           = WIDTH_RESET;
        img_height          = HEIGHT_RESET;
        col_pos             = '0;
        row_pos             = '0;
        for (int i = 0; i < LINE_MAX_DEF; i++)
        begin
            lb_upper[i]  = '0;
            lb_middle[i] = '0;
        end
        for (int i = 0; i < 9; i++)
            win[i] = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Width and height below the minimum: two full 3x3 frames, the second
        // one reached by wrap-around, then a frame cut short by a restart.
        write_reg(REG_IMAGE_WIDTH, 16'hF800);
        write_reg(REG_IMAGE_HEIGHT, 16'h0001);
        for (int k = 0; k < 25; k++)
        begin
            pending_pixels.push_back(pix_item_t'({DIRECT_PIXELS[k], DIRECT_STARTS[k]}));
            pushed = pushed + 1;
        end
        wait_drained();

        // The output is held off for a long stretch while pixels keep coming.
        set_size(64, 4);
        push_run(64 * 4, TEX_NOISE, 0, 1'b1);
        hold_req = hold_req + 1;
        wait_drained();

        // Shrink both sizes with the counters already past the new limits.
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        set_size(40, 6);
        push_run(40 * 3 + 31, TEX_NOISE, 0, 1'b1);
        wait_drained();
        set_size(20, 3);
        push_run(20 * 3 * 3, TEX_BINARY, 0, 1'b0);
        wait_drained();

        set_size(3, 65535);
        push_run(3 * 40, TEX_NOISE, 0, 1'b1);
        wait_drained();

        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 63;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 63;
                end
                default:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                end
            endcase
            mode_items = 0;
            while (mode_items < ITEMS_PER_MODE)
            begin
                wide = ($urandom_range(9) == 0);
                w = wide ? $urandom_range(60, 100) : $urandom_range(0, 24);
                h = wide ? $urandom_range(0, 3) : $urandom_range(0, 6);
                eff_w = (w < MIN_DIM) ? MIN_DIM : w;
                eff_h = (h < MIN_DIM) ? MIN_DIM : h;
                if (wide)
                    n = eff_w * eff_h + $urandom_range(0, eff_w);
                else
                begin
                    n = eff_w * eff_h * $urandom_range(1, 2);
                    n = n + $urandom_range(0, eff_w * eff_h - 1);
                end
                set_size(w, h);
                push_run(n, texture_t'($urandom_range(2)), ($urandom_range(3) == 0) ? 3 : 0,
                         1'b1);
                wait_drained();
                mode_items = mode_items + n;
            end
        end

        if (errors == 0)
            $display("prewitt_edge_magnitude_3x3_top: match");
        else
            $display("prewitt_edge_magnitude_3x3_top: mismatch");
        $finish;
    end

endmodule
